### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/u8u16_pkg.sv
package u8u16_pkg;

	// Slot kinds in a job handed from the front to the back.
	localparam logic [1:0] KIND_SINGLE = 2'd0;
	localparam logic [1:0] KIND_HI     = 2'd1;
	localparam logic [1:0] KIND_LO     = 2'd2;
	localparam logic [1:0] KIND_TERM   = 2'd3;

	localparam int unsigned SLOTS      = 4;
	localparam int unsigned QDEPTH     = 4;

	localparam logic [15:0] CAP_RESET  = 16'd40;
	localparam logic [15:0] REPL_CHAR  = 16'hFFFD;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h010000;
	localparam logic [20:0] MIN_2B     = 21'h000080;
	localparam logic [20:0] MIN_3B     = 21'h000800;
	localparam logic [15:0] HI_TAG     = 16'hD800;
	localparam logic [15:0] LO_TAG     = 16'hDC00;

	typedef struct packed {
		logic [2:0]              cnt;
		logic [SLOTS-1:0][1:0]   kinds;
		logic [SLOTS-1:0][15:0]  units;
	} job_t;

	function automatic job_t job_add(job_t j, logic [1:0] kind, logic [15:0] unit);
		job_t r;
		r = j;
		r.kinds[j.cnt[1:0]] = kind;
		r.units[j.cnt[1:0]] = unit;
		r.cnt = j.cnt + 3'd1;
		return r;
	endfunction

endpackage

### rtl/core/u8u16_if.sv
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        is_last;
	modport source (output valid, output code_unit, output is_last, input ready);
	modport sink (input valid, input code_unit, input is_last, output ready);
endinterface

interface u8u16_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_capacity;
	modport source (output valid, output out_capacity, input ready);
	modport sink (input valid, input out_capacity, output ready);
endinterface

### rtl/core/utf8_to_utf16_transcoder_core.sv
// UTF-8 to UTF-16 transcoder. One UTF-8 byte per transfer on in_ch; a zero
// byte ends the string and always yields a zero unit with is_last set, after
// which all string state starts over. Code units leave on out_ch, a surrogate
// pair for code points above U+FFFF. Malformed, overlong, surrogate-range and
// out-of-range sequences give U+FFFD followed by their continuation bytes as
// raw values; stray continuation bytes and F8-FF pass through raw. Output of
// data units stops once out_capacity (terminator included) would be exceeded.
// Rate: the front takes one byte every cycle while the job queue (4 entries)
// has room. The back emits or drops one queued unit per cycle while out_ch
// does not stall; a byte yields one candidate unit for ASCII, one or two for
// a completed sequence, up to four for an error burst, none for bytes that
// only open or extend a pending sequence. With the queue empty, the first
// unit of a byte passes the job queue and then the output register before
// out_ch offers it. Write out_capacity on cfg_ch only while no string is in
// flight; it resets to 40.
module utf8_to_utf16_transcoder_core
	import u8u16_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	u8u16_cfg_if.sink    cfg_ch,
	u8u16_byte_if.sink   in_ch,
	u8u16_unit_if.source out_ch
);

	logic [15:0] cap_q;
	logic        q_full, q_valid, push, pop;
	job_t        push_job, head;

	// capacity register, always ready for a write transfer
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_ch.valid) begin
			cap_q <= cfg_ch.out_capacity;
		end
	end

	// front: sequence tracking and classification into unit jobs
	u8u16_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.job    (push_job)
	);

	// decoupling queue of jobs
	u8u16_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.not_empty (q_valid),
		.pop       (pop),
		.head      (head)
	);

	// back: capacity gating and output register, one unit per cycle unless out_ch stalls
	u8u16_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cap     (cap_q),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

### rtl/core/u8u16_front.sv
`include "assert_macros.svh"

module u8u16_front
	import u8u16_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	u8u16_byte_if.sink in_ch,
	input  logic   q_full,
	output logic   push,
	output job_t   job
);

	logic [2:0]       len_q, len_d;
	logic [1:0]       rcv_q, rcv_d;
	logic [20:0]      acc_q, acc_d;
	logic [1:0][7:0]  held_q, held_d;
	logic [20:0]      acc_n, cp_off, cp_min;
	logic [7:0]       b;
	logic             accept, do_idle, bad;
	job_t             j;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;
	assign b           = in_ch.in_byte;
	assign acc_n       = {acc_q[14:0], b[5:0]};
	assign cp_off      = acc_n - SUPP_BASE;

	always_comb begin
		case (len_q)
			3'd2:    cp_min = MIN_2B;
			3'd3:    cp_min = MIN_3B;
			default: cp_min = SUPP_BASE;
		endcase
	end

	assign bad = (acc_n < cp_min) || (acc_n > CP_MAX) || (acc_n >= SURR_LO && acc_n <= SURR_HI);

	always_comb begin
		j       = '0;
		len_d   = len_q;
		rcv_d   = rcv_q;
		acc_d   = acc_q;
		held_d  = held_q;
		do_idle = 1'b0;
		if (len_q == 3'd0) begin
			do_idle = 1'b1;
		end else if (b[7:6] != 2'b10) begin
			// broken sequence: FFFD, held bytes raw, then this byte afresh
			j = job_add(j, KIND_SINGLE, REPL_CHAR);
			if (rcv_q >= 2'd1) j = job_add(j, KIND_SINGLE, {8'h00, held_q[0]});
			if (rcv_q >= 2'd2) j = job_add(j, KIND_SINGLE, {8'h00, held_q[1]});
			len_d   = 3'd0;
			rcv_d   = 2'd0;
			acc_d   = '0;
			held_d  = '0;
			do_idle = 1'b1;
		end else if ({1'b0, rcv_q} + 3'd2 >= len_q) begin
			if (bad) begin
				j = job_add(j, KIND_SINGLE, REPL_CHAR);
				if (rcv_q >= 2'd1) j = job_add(j, KIND_SINGLE, {8'h00, held_q[0]});
				if (rcv_q >= 2'd2) j = job_add(j, KIND_SINGLE, {8'h00, held_q[1]});
				j = job_add(j, KIND_SINGLE, {8'h00, b});
			end else if (acc_n < SUPP_BASE) begin
				j = job_add(j, KIND_SINGLE, acc_n[15:0]);
			end else begin
				j = job_add(j, KIND_HI, HI_TAG | {6'd0, cp_off[19:10]});
				j = job_add(j, KIND_LO, LO_TAG | {6'd0, cp_off[9:0]});
			end
			len_d  = 3'd0;
			rcv_d  = 2'd0;
			acc_d  = '0;
			held_d = '0;
		end else begin
			held_d[rcv_q[0]] = b;
			rcv_d = rcv_q + 2'd1;
			acc_d = acc_n;
		end

		if (do_idle) begin
			case (b) inside
				8'h00:          j = job_add(j, KIND_TERM, 16'h0000);
				[8'hC0:8'hDF]: begin
					len_d = 3'd2;
					acc_d = {16'd0, b[4:0]};
				end
				[8'hE0:8'hEF]: begin
					len_d = 3'd3;
					acc_d = {17'd0, b[3:0]};
				end
				[8'hF0:8'hF7]: begin
					len_d = 3'd4;
					acc_d = {18'd0, b[2:0]};
				end
				default:        j = job_add(j, KIND_SINGLE, {8'h00, b});
			endcase
		end
	end

	assign job  = j;
	assign push = accept && (j.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= 3'd0;
			rcv_q  <= 2'd0;
			acc_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			len_q  <= len_d;
			rcv_q  <= rcv_d;
			acc_q  <= acc_d;
			held_q <= held_d;
		end
	end

	`ASSERT_CLK(a_len_legal, clk, arst_n,
		len_q == 3'd0 || len_q == 3'd2 || len_q == 3'd3 || len_q == 3'd4)
	`ASSERT_CLK(a_rcv_bound, clk, arst_n,
		(len_q == 3'd0 && rcv_q == 2'd0) || ({1'b0, rcv_q} + 3'd2 <= len_q))

endmodule

### rtl/core/u8u16_queue.sv
`include "assert_macros.svh"

module u8u16_queue
	import u8u16_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	output logic not_empty,
	input  logic pop,
	output job_t head
);

	localparam int unsigned PW = $clog2(QDEPTH);

	job_t            mem_q [QDEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;

	assign full      = (cnt_q == (PW+1)'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop)  rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	`ASSERT_CLK(a_cnt_bound, clk, arst_n, cnt_q <= (PW+1)'(QDEPTH))
	`ASSERT_CLK(a_no_underflow, clk, arst_n, !(pop && cnt_q == '0))

endmodule

### rtl/core/u8u16_back.sv
`include "assert_macros.svh"

module u8u16_back
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] cap,
	input  logic        q_valid,
	input  job_t        head,
	output logic        pop,
	u8u16_unit_if.source out_ch
);

	logic [1:0]  idx_q;
	logic [15:0] uw_q, uw_d;
	logic        full_q, full_d;
	logic        out_valid_q, is_last_q;
	logic [15:0] unit_q;
	logic        out_free, step, emit, last_slot;
	logic [1:0]  kind;
	logic [15:0] unit;
	logic [16:0] need1, need2;

	assign out_free  = !out_valid_q || out_ch.ready;
	assign step      = q_valid && out_free;
	assign kind      = head.kinds[idx_q];
	assign unit      = head.units[idx_q];
	assign last_slot = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign pop       = step && last_slot;
	assign need1     = {1'b0, uw_q} + 17'd1;
	assign need2     = {1'b0, uw_q} + 17'd2;

	// Capacity gate: a unit needs room for itself plus the terminator;
	// a surrogate pair is judged as a whole on its high half.
	always_comb begin
		emit   = 1'b0;
		uw_d   = uw_q;
		full_d = full_q;
		case (kind)
			KIND_TERM: begin
				emit   = 1'b1;
				uw_d   = '0;
				full_d = 1'b0;
			end
			KIND_SINGLE: begin
				if (!full_q) begin
					if (need1 >= {1'b0, cap}) begin
						full_d = 1'b1;
					end else begin
						emit = 1'b1;
						uw_d = need1[15:0];
					end
				end
			end
			KIND_HI: begin
				if (!full_q) begin
					if (need2 >= {1'b0, cap}) begin
						full_d = 1'b1;
					end else begin
						emit = 1'b1;
						uw_d = need1[15:0];
					end
				end
			end
			KIND_LO: begin
				if (!full_q) begin
					emit = 1'b1;
					uw_d = need1[15:0];
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			uw_q        <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				idx_q  <= last_slot ? 2'd0 : idx_q + 2'd1;
				uw_q   <= uw_d;
				full_q <= full_d;
			end
			if (out_free) out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			unit_q    <= unit;
			is_last_q <= (kind == KIND_TERM);
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.code_unit = unit_q;
	assign out_ch.is_last   = is_last_q;

	`ASSERT_CLK(a_slot_in_job, clk, arst_n, !q_valid || ({1'b0, idx_q} < head.cnt))
	`ASSERT_NEXT(a_term_clears, clk, arst_n, step && kind == KIND_TERM,
		uw_q == 16'd0 && !full_q && out_valid_q && is_last_q)

endmodule

### test/utf8_to_utf16_transcoder_core_test.sv
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_core_test;

	// Values of the conversion itself, kept apart from the design package
	localparam logic [15:0] REPLACEMENT = 16'hFFFD;
	localparam logic [20:0] CP_LIMIT    = 21'h10FFFF;
	localparam logic [20:0] SURR_FIRST  = 21'h00D800;
	localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
	localparam logic [20:0] PLANE1      = 21'h010000;
	localparam logic [20:0] FLOOR_2B    = 21'h000080;
	localparam logic [20:0] FLOOR_3B    = 21'h000800;
	localparam logic [15:0] HIGH_TAG    = 16'hD800;
	localparam logic [15:0] LOW_TAG     = 16'hDC00;
	localparam logic [7:0]  STRING_END  = 8'h00;
	localparam logic [15:0] CAP_AT_RESET = 16'd40;

	// Run control
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on any channel
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
	localparam int DRAIN_CYCLES   = 8;     // margin after the last predicted unit has come out
	localparam int RANDOM_BYTES   = 370;

	typedef struct {
		logic [15:0] code;
		logic        term;
	} unit_t;

	logic clk;
	logic arst_n;

	u8u16_cfg_if  cap_ch ();
	u8u16_byte_if byte_ch ();
	u8u16_unit_if unit_ch ();

	utf8_to_utf16_transcoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cap_ch),
		.in_ch  (byte_ch),
		.out_ch (unit_ch)
	);

	// Code units predicted but not yet seen on the output, oldest first
	unit_t units_due[$];

	// Predictor state: capacity register plus the per-string decoder state
	logic [15:0] m_capacity = CAP_AT_RESET;
	logic [2:0]  m_seq_len  = '0;
	logic [1:0]  m_seq_cnt  = '0;
	logic [20:0] m_accum    = '0;
	logic [7:0]  m_held [2] = '{8'h00, 8'h00};
	logic [15:0] m_written  = '0;
	logic        m_full     = 1'b0;

	// Stimulus knobs, changed per phase
	int src_gap_pct    = 0;
	int sink_stall_pct = 0;
	bit hold_req       = 1'b0;

	// Bookkeeping
	int fails         = 0;
	int bytes_sent    = 0;
	int bytes_taken   = 0;
	int units_checked = 0;
	int strings_done  = 0;
	int cap_writes    = 0;

	logic [7:0] text_q[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void push_unit(logic [15:0] code, logic term);
		unit_t u;
		u.code = code;
		u.term = term;
		units_due.push_back(u);
	endfunction

	function automatic void clear_sequence();
		m_seq_len = '0;
		m_seq_cnt = '0;
		m_accum   = '0;
		m_held[0] = '0;
		m_held[1] = '0;
	endfunction

	// One data unit, subject to the capacity; once full, stays full until the terminator
	function automatic void emit_unit(logic [15:0] code);
		if (m_full)
			return;
		if ({16'd0, m_written} + 32'd1 >= {16'd0, m_capacity}) begin
			m_full = 1'b1;
			return;
		end
		push_unit(code, 1'b0);
		m_written = m_written + 16'd1;
	endfunction

	// BMP code points go out as one unit, the rest as a surrogate pair that must fit whole
	function automatic void emit_code_point(logic [20:0] cp);
		logic [20:0] off;
		if (cp < PLANE1) begin
			emit_unit(cp[15:0]);
			return;
		end
		if (m_full)
			return;
		if ({16'd0, m_written} + 32'd2 >= {16'd0, m_capacity}) begin
			m_full = 1'b1;
			return;
		end
		off = cp - PLANE1;
		push_unit(HIGH_TAG | {6'd0, off[19:10]}, 1'b0);
		push_unit(LOW_TAG | {6'd0, off[9:0]}, 1'b0);
		m_written = m_written + 16'd2;
	endfunction

	// Replacement char for the lead byte, then the continuation bytes held so far, raw
	function automatic void emit_error_and_held();
		emit_unit(REPLACEMENT);
		for (int i = 0; i < m_seq_cnt && i < 2; i++)
			emit_unit({8'd0, m_held[i]});
	endfunction

	// Byte seen with no sequence open
	function automatic void take_free_byte(logic [7:0] b);
		if (b == STRING_END) begin
			push_unit(16'h0000, 1'b1);
			clear_sequence();
			m_written = '0;
			m_full    = 1'b0;
			return;
		end
		if (m_full)
			return;
		if (b[7:5] == 3'b110) begin
			m_seq_len = 3'd2;
			m_accum   = {16'd0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			m_seq_len = 3'd3;
			m_accum   = {17'd0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			m_seq_len = 3'd4;
			m_accum   = {18'd0, b[2:0]};
		end else begin
			// ASCII, stray continuation byte or F8-FF: raw value
			emit_unit({8'd0, b});
		end
	endfunction

	// Byte seen while a multi-byte sequence is open
	function automatic void take_seq_byte(logic [7:0] b);
		logic [20:0] floor_cp;
		if (b[7:6] != 2'b10) begin
			// broken sequence: flush it, then treat this byte as a fresh one
			emit_error_and_held();
			clear_sequence();
			take_free_byte(b);
			return;
		end
		m_accum = {m_accum[14:0], b[5:0]};
		if ({30'd0, m_seq_cnt} + 32'd2 >= {29'd0, m_seq_len}) begin
			floor_cp = (m_seq_len == 3'd2) ? FLOOR_2B :
				(m_seq_len == 3'd3) ? FLOOR_3B : PLANE1;
			if (m_accum < floor_cp || m_accum > CP_LIMIT ||
					(m_accum >= SURR_FIRST && m_accum <= SURR_LAST)) begin
				// overlong, surrogate or out of range: every continuation byte raw
				emit_error_and_held();
				emit_unit({8'd0, b});
			end else begin
				emit_code_point(m_accum);
			end
			clear_sequence();
		end else begin
			m_held[m_seq_cnt[0]] = b;
			m_seq_cnt = m_seq_cnt + 2'd1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: check units first (they belong to older bytes), then
	// apply config and predict from the byte taken at this edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		unit_t want;
		if (arst_n) begin
			if (unit_ch.valid && unit_ch.ready) begin
				units_checked++;
				if (units_due.size() == 0) begin
					fails++;
					$display("%0t: unexpected unit: expected none, actual code %h last %b",
						$time, unit_ch.code_unit, unit_ch.is_last);
				end else begin
					want = units_due.pop_front();
					if (want.code !== unit_ch.code_unit) begin
						fails++;
						$display("%0t: code_unit mismatch: expected %h, actual %h",
							$time, want.code, unit_ch.code_unit);
					end
					if (want.term !== unit_ch.is_last) begin
						fails++;
						$display("%0t: is_last mismatch: expected %b, actual %b",
							$time, want.term, unit_ch.is_last);
					end
				end
			end
			if (cap_ch.valid && cap_ch.ready)
				m_capacity = cap_ch.out_capacity;
			if (byte_ch.valid && byte_ch.ready) begin
				bytes_taken++;
				if (byte_ch.in_byte == STRING_END)
					strings_done++;
				if (m_seq_len != 3'd0)
					take_seq_byte(byte_ch.in_byte);
				else
					take_free_byte(byte_ch.in_byte);
			end
		end
	end

	// Watchdog: any transfer on any channel restarts the count
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready) ||
					(cap_ch.valid && cap_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: timeout, no transfer for %0d cycles, %0d units still due",
			$time, idle_cycles, units_due.size());
		$display("[utf8_to_utf16_transcoder_core] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 20);
		return $urandom_range(3, 1);
	endfunction

	// Receiver: random stalls, or one long hold-off on request
	initial begin
		int stall;
		unit_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				unit_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				stall = pick_gap(sink_stall_pct);
				if (stall == 0) begin
					unit_ch.ready = 1'b1;
				end else begin
					unit_ch.ready = 1'b0;
					repeat (stall - 1) @(negedge clk);
				end
			end
		end
	end

	// One byte transfer; valid stays up on return so back-to-back bytes need no bubble
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap(src_gap_pct);
		repeat (gap) begin
			@(negedge clk);
			byte_ch.valid   = 1'b0;
			byte_ch.in_byte = 8'($urandom);
		end
		@(negedge clk);
		byte_ch.valid   = 1'b1;
		byte_ch.in_byte = b;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_byte(text_q[i]);
		text_q.delete();
	endtask

	task automatic send_code_point(input logic [20:0] cp);
		if (cp < FLOOR_2B) begin
			send_byte(cp[7:0]);
		end else if (cp < FLOOR_3B) begin
			send_byte({3'b110, cp[10:6]});
			send_byte({2'b10, cp[5:0]});
		end else if (cp < PLANE1) begin
			send_byte({4'b1110, cp[15:12]});
			send_byte({2'b10, cp[11:6]});
			send_byte({2'b10, cp[5:0]});
		end else begin
			send_byte({5'b11110, cp[20:18]});
			send_byte({2'b10, cp[17:12]});
			send_byte({2'b10, cp[11:6]});
			send_byte({2'b10, cp[5:0]});
		end
	endtask

	// Drop valid and wait until every predicted unit has come out
	task automatic settle();
		@(negedge clk);
		byte_ch.valid = 1'b0;
		while (units_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Capacity write, only with the block idle between strings
	task automatic set_capacity(input logic [15:0] cap);
		settle();
		@(negedge clk);
		cap_ch.valid        = 1'b1;
		cap_ch.out_capacity = cap;
		do @(posedge clk); while (!cap_ch.ready);
		cap_writes++;
		@(negedge clk);
		cap_ch.valid        = 1'b0;
		cap_ch.out_capacity = 16'($urandom);
	endtask

	function automatic logic [15:0] pick_capacity();
		case ($urandom_range(5))
			0: return 16'($urandom_range(6, 1));
			1: return CAP_AT_RESET;
			2: return 16'hFFFF;
			3: return 16'($urandom);
			4: return 16'($urandom_range(12, 2));
			default: return 16'h0000;
		endcase
	endfunction

	// One random character: mostly well-formed, the rest noise and broken sequences
	task automatic send_random_char();
		int pick;
		int need;
		int k;
		logic [20:0] cp;
		logic [7:0] lead;
		pick = $urandom_range(99);
		if (pick < 40) begin
			send_byte(8'($urandom_range(127, 1)));
		end else if (pick < 55) begin
			send_code_point(21'($urandom_range(16'h07FF, 16'h0080)));
		end else if (pick < 70) begin
			cp = 21'($urandom_range(16'hFFFF, 16'h0800));
			if (cp >= SURR_FIRST && cp <= SURR_LAST)
				cp = cp + 21'h800;
			send_code_point(cp);
		end else if (pick < 80) begin
			send_code_point(21'($urandom_range(21'h10FFFF, 21'h010000)));
		end else if (pick < 85) begin
			// stray byte: lone continuation byte or F8-FF
			if ($urandom_range(1))
				send_byte(8'($urandom_range(8'hBF, 8'h80)));
			else
				send_byte(8'($urandom_range(8'hFF, 8'hF8)));
		end else if (pick < 90) begin
			// truncated sequence, the next byte breaks it unless it is a continuation byte
			lead = 8'($urandom_range(8'hF7, 8'hC0));
			need = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
			k = $urandom_range(need - 1, 0);
			send_byte(lead);
			repeat (k) send_byte(8'($urandom_range(8'hBF, 8'h80)));
		end else if (pick < 95) begin
			// complete sequence with a bad value: overlong, surrogate or above U+10FFFF
			case ($urandom_range(5))
				0: begin
					send_byte(8'($urandom_range(8'hC1, 8'hC0)));
					need = 1;
				end
				1: begin
					send_byte(8'hE0);
					send_byte(8'($urandom_range(8'h9F, 8'h80)));
					need = 1;
				end
				2: begin
					send_byte(8'hED);
					send_byte(8'($urandom_range(8'hBF, 8'hA0)));
					need = 1;
				end
				3: begin
					send_byte(8'hF0);
					send_byte(8'($urandom_range(8'h8F, 8'h80)));
					need = 2;
				end
				4: begin
					send_byte(8'hF4);
					send_byte(8'($urandom_range(8'hBF, 8'h90)));
					need = 2;
				end
				default: begin
					send_byte(8'($urandom_range(8'hF7, 8'hF5)));
					need = 3;
				end
			endcase
			repeat (need) send_byte(8'($urandom_range(8'hBF, 8'h80)));
		end else begin
			send_byte(8'($urandom_range(255, 1)));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Valid 2/3/4-byte forms and the top code point, then every error class,
	// all at the reset capacity
	task automatic test_directed();
		src_gap_pct    = 30;
		sink_stall_pct = 30;
		// 7F, U+00A9, U+20AC, U+10FFFF
		text_q = {8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
			8'hF4, 8'h8F, 8'hBF, 8'hBF, STRING_END};
		send_text();
		// overlong C0 80, surrogate ED A0 80, stray 80, F7 BF BF BF above range,
		// raw FF, F0 9F 98 broken by 'A', E2 cut off by the terminator
		text_q = {8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'h80,
			8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hFF,
			8'hF0, 8'h9F, 8'h98, 8'h41, 8'hE2, STRING_END};
		send_text();
		settle();
	endtask

	// Capacity edge cases: zero and one give only the terminator, a pair that
	// does not fit stops output, the maximum never fills
	task automatic test_capacity_limits();
		logic [15:0] caps [6];
		caps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'hFFFF};
		src_gap_pct    = 0;
		sink_stall_pct = 50;
		foreach (caps[i]) begin
			set_capacity(caps[i]);
			// 'A', U+1F600, 'B', U+20AC
			text_q = {8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h42,
				8'hE2, 8'h82, 8'hAC, STRING_END};
			send_text();
		end
		settle();
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the job queue fills and the input stalls
	task automatic test_output_backpressure();
		set_capacity(16'hFFFF);
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		hold_req       = 1'b1;
		repeat (8) send_code_point(21'($urandom_range(21'h10FFFF, 21'h010000)));
		repeat (4) send_random_char();
		send_byte(STRING_END);
		while (hold_req) @(posedge clk);
		settle();
	endtask

	// Random strings, random capacities between them, idling varied per string
	task automatic test_random_text();
		int stop_at;
		int n_chars;
		stop_at = bytes_sent + RANDOM_BYTES;
		set_capacity(pick_capacity());
		while (bytes_sent < stop_at) begin
			if ($urandom_range(9) < 3)
				set_capacity(pick_capacity());
			case ($urandom_range(2))
				0: src_gap_pct = 0;
				1: src_gap_pct = 20;
				default: src_gap_pct = 60;
			endcase
			case ($urandom_range(2))
				0: sink_stall_pct = 0;
				1: sink_stall_pct = 20;
				default: sink_stall_pct = 60;
			endcase
			n_chars = $urandom_range(16, 1);
			repeat (n_chars) send_random_char();
			send_byte(STRING_END);
		end
		settle();
	endtask

	initial begin
		arst_n              = 1'b0;
		byte_ch.valid       = 1'b0;
		byte_ch.in_byte     = 8'h00;
		cap_ch.valid        = 1'b0;
		cap_ch.out_capacity = 16'h0000;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_capacity_limits();
		test_output_backpressure();
		test_random_text();

		$display("Covered %0d bytes in %0d strings, %0d code units checked,",
			bytes_taken, strings_done, units_checked);
		$display("%0d capacity writes from 0 to 65535, one long output hold-off; %0d failures.",
			cap_writes, fails);
		if (fails == 0)
			$display("[utf8_to_utf16_transcoder_core] OK");
		else
			$display("[utf8_to_utf16_transcoder_core] ERROR");
		$finish;
	end

endmodule

### utf8_to_utf16_transcoder_core.f
+incdir+rtl/core
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_if.sv
rtl/core/u8u16_front.sv
rtl/core/u8u16_queue.sv
rtl/core/u8u16_back.sv
rtl/core/utf8_to_utf16_transcoder_core.sv
test/utf8_to_utf16_transcoder_core_test.sv
